### hw/rtl/tfsp_pkg.sv
// ----------------------------------------------------------------------------
// tfsp_pkg
// shared types, byte codes and defaults for the frame stream parser
// ----------------------------------------------------------------------------
package tfsp_pkg;

    localparam int LABEL_MAX_DEF   = 8;
    localparam int VALUE_MAX_DEF   = 32;
    localparam int CHECK_MAX_DEF   = 2;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int LEN_W  = 6;
    localparam int ADDR_W = 3;

    localparam logic [7:0] B_STX   = 8'h02;
    localparam logic [7:0] B_ETX   = 8'h03;
    localparam logic [7:0] B_LF    = 8'h0A;
    localparam logic [7:0] B_CR    = 8'h0D;
    localparam logic [7:0] SEP_STD = 8'h09;
    localparam logic [7:0] SEP_OLD = 8'h20;

    localparam logic [6:0] CK_OFFSET = 7'h20;

    localparam logic [7:0] MAX_DATASETS_RST = 8'd64;

    localparam logic REG_LEGACY_MODE  = 1'b0;
    localparam logic REG_MAX_DATASETS = 1'b1;

    typedef enum logic [2:0] {
        CLS_STX  = 3'd0,
        CLS_ETX  = 3'd1,
        CLS_LF   = 3'd2,
        CLS_CR   = 3'd3,
        CLS_SEP  = 3'd4,
        CLS_DATA = 3'd5
    } byte_class_t;

    typedef enum logic [2:0] {
        EV_IGNORE = 3'd0,
        EV_FSTART = 3'd1,
        EV_DSTART = 3'd2,
        EV_DATA   = 3'd3,
        EV_SEP    = 3'd4,
        EV_DSOK   = 3'd5,
        EV_FEND   = 3'd6,
        EV_ERR    = 3'd7
    } event_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_STX       = 3'd1,
        ERR_DATASETS  = 3'd2,
        ERR_FIELDS    = 3'd3,
        ERR_LENGTH    = 3'd4,
        ERR_CHECKSUM  = 3'd5,
        ERR_OUTSIDE   = 3'd6
    } err_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        byte_class_t cls;
    } entry_t;

    typedef struct packed {
        event_t     ev;
        logic [1:0] field_index;
        logic [7:0] data_char;
        logic       has_timestamp;
        err_t       err;
        logic [6:0] ck;
    } result_t;

    typedef struct packed {
        logic       legacy_mode;
        logic [7:0] max_datasets;
    } cfg_t;

endpackage

### hw/rtl/tfsp_if.sv
// ----------------------------------------------------------------------------
// tfsp_in_if / tfsp_out_if
// valid/ready channels for received bytes and parser results
// ----------------------------------------------------------------------------
interface tfsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfsp_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [1:0] field_index;
    logic [7:0] data_char;
    logic       has_timestamp;
    logic [2:0] error_code;
    logic [6:0] computed_checksum;

    modport source (
        output valid, output event_res, output field_index, output data_char,
        output has_timestamp, output error_code, output computed_checksum,
        input ready
    );
    modport sink (
        input valid, input event_res, input field_index, input data_char,
        input has_timestamp, input error_code, input computed_checksum,
        output ready
    );
endinterface

### hw/rtl/tfsp_front.sv
// ----------------------------------------------------------------------------
// tfsp_front
// accepts received bytes and tags each with its byte class
// ----------------------------------------------------------------------------
module tfsp_front
    import tfsp_pkg::*;
(
    tfsp_in_if.sink in_ch,
    input  logic    legacy_mode,
    input  logic    q_full,
    output logic    push,
    output entry_t  push_entry
);

    logic [7:0] sep;

    assign sep         = legacy_mode ? SEP_OLD : SEP_STD;
    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    always_comb
    begin
        push_entry.rx_byte = in_ch.rx_byte;
        if (in_ch.rx_byte == B_STX)
        begin
            push_entry.cls = CLS_STX;
        end
        else if (in_ch.rx_byte == B_ETX)
        begin
            push_entry.cls = CLS_ETX;
        end
        else if (in_ch.rx_byte == B_LF)
        begin
            push_entry.cls = CLS_LF;
        end
        else if (in_ch.rx_byte == B_CR)
        begin
            push_entry.cls = CLS_CR;
        end
        else if (in_ch.rx_byte == sep)
        begin
            push_entry.cls = CLS_SEP;
        end
        else
        begin
            push_entry.cls = CLS_DATA;
        end
    end

endmodule

### hw/rtl/tfsp_queue.sv
// ----------------------------------------------------------------------------
// tfsp_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
module tfsp_queue
    import tfsp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   q_valid,
    output entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hw/rtl/tfsp_back.sv
// ----------------------------------------------------------------------------
// tfsp_back
// frame and dataset state machine, checksum check and result register
// ----------------------------------------------------------------------------
module tfsp_back
    import tfsp_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF,
    parameter int VALUE_MAX = VALUE_MAX_DEF,
    parameter int CHECK_MAX = CHECK_MAX_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_valid,
    input  entry_t  head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic             in_frame_reg,    in_frame_next;
    logic             in_dataset_reg,  in_dataset_next;
    logic [1:0]       cur_field_reg,   cur_field_next;
    logic [LEN_W-1:0] field_len_reg,   field_len_next;
    logic [5:0]       run_sum_reg,     run_sum_next;
    logic [5:0]       sum3_reg,        sum3_next;
    logic [5:0]       sum4_reg,        sum4_next;
    logic [7:0]       first2_reg,      first2_next;
    logic [7:0]       first3_reg,      first3_next;
    logic [7:0]       ds_count_reg,    ds_count_next;
    logic             out_valid_reg,   out_valid_next;
    result_t          res_reg,         res_next;

    logic [7:0]       sep;
    logic [7:0]       last_sep;
    logic [7:0]       ch;
    logic             four;
    logic [5:0]       sum;
    logic [6:0]       ck;
    logic [7:0]       expect_ch;
    logic [LEN_W-1:0] limit;
    logic             clear_all;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    assign sep      = cfg.legacy_mode ? SEP_OLD : SEP_STD;
    assign last_sep = cfg.legacy_mode ? 8'h00 : sep;
    assign ch       = head.rx_byte;

    // checksum candidates at cr
    assign four = (cur_field_reg == 2'd3) && (first3_reg != 8'h00);

    always_comb
    begin
        if (four)
        begin
            sum       = sum4_reg;
            expect_ch = first3_reg;
        end
        else
        begin
            if (cur_field_reg >= 2'd2)
            begin
                sum = sum3_reg;
            end
            else
            begin
                sum = run_sum_reg + ((cur_field_reg == 2'd0) ? sep[5:0] : 6'd0)
                      + last_sep[5:0];
            end
            expect_ch = first2_reg;
        end
        ck = {1'b0, sum} + CK_OFFSET;
    end

    always_comb
    begin
        case (cur_field_reg)
            2'd0:    limit = LEN_W'(LABEL_MAX);
            2'd3:    limit = LEN_W'(CHECK_MAX);
            default: limit = LEN_W'(VALUE_MAX);
        endcase
    end

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        in_dataset_next = in_dataset_reg;
        cur_field_next  = cur_field_reg;
        field_len_next  = field_len_reg;
        run_sum_next    = run_sum_reg;
        sum3_next       = sum3_reg;
        sum4_next       = sum4_reg;
        first2_next     = first2_reg;
        first3_next     = first3_reg;
        ds_count_next   = ds_count_reg;
        out_valid_next  = out_valid_reg;
        res_next        = res_reg;
        clear_all       = 1'b0;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            out_valid_next         = 1'b1;
            res_next               = '0;
            res_next.ev            = EV_IGNORE;
            res_next.err           = ERR_NONE;
            if (head.cls == CLS_STX)
            begin
                clear_all = 1'b1;
                if (in_frame_reg)
                begin
                    res_next.ev  = EV_ERR;
                    res_next.err = ERR_STX;
                end
                else
                begin
                    res_next.ev = EV_FSTART;
                end
            end
            else if (!in_frame_reg)
            begin
                res_next.ev = EV_IGNORE;
            end
            else if (head.cls == CLS_ETX)
            begin
                clear_all   = 1'b1;
                res_next.ev = EV_FEND;
            end
            else if (head.cls == CLS_LF)
            begin
                if (ds_count_reg >= cfg.max_datasets)
                begin
                    clear_all    = 1'b1;
                    res_next.ev  = EV_ERR;
                    res_next.err = ERR_DATASETS;
                end
                else
                begin
                    in_dataset_next = 1'b1;
                    cur_field_next  = 2'd0;
                    field_len_next  = '0;
                    run_sum_next    = '0;
                    sum3_next       = '0;
                    sum4_next       = '0;
                    first2_next     = '0;
                    first3_next     = '0;
                    res_next.ev     = EV_DSTART;
                end
            end
            else if (!in_dataset_reg)
            begin
                clear_all    = 1'b1;
                res_next.ev  = EV_ERR;
                res_next.err = ERR_OUTSIDE;
            end
            else if (head.cls == CLS_CR)
            begin
                res_next.ck = ck;
                if ({1'b0, ck} != expect_ch)
                begin
                    clear_all    = 1'b1;
                    res_next.ev  = EV_ERR;
                    res_next.err = ERR_CHECKSUM;
                end
                else
                begin
                    in_dataset_next        = 1'b0;
                    ds_count_next          = ds_count_reg + 1'b1;
                    res_next.ev            = EV_DSOK;
                    res_next.has_timestamp = four;
                end
            end
            else if (head.cls == CLS_SEP)
            begin
                if (cur_field_reg == 2'd3)
                begin
                    clear_all    = 1'b1;
                    res_next.ev  = EV_ERR;
                    res_next.err = ERR_FIELDS;
                end
                else
                begin
                    if (cur_field_reg == 2'd1)
                    begin
                        sum3_next = run_sum_reg + last_sep[5:0];
                    end
                    if (cur_field_reg == 2'd2)
                    begin
                        sum4_next = run_sum_reg + last_sep[5:0];
                    end
                    run_sum_next         = run_sum_reg + sep[5:0];
                    cur_field_next       = cur_field_reg + 2'd1;
                    field_len_next       = '0;
                    res_next.ev          = EV_SEP;
                    res_next.field_index = cur_field_reg;
                end
            end
            else
            begin
                if (field_len_reg >= limit)
                begin
                    clear_all    = 1'b1;
                    res_next.ev  = EV_ERR;
                    res_next.err = ERR_LENGTH;
                end
                else
                begin
                    if (field_len_reg == '0)
                    begin
                        if (cur_field_reg == 2'd2)
                        begin
                            first2_next = ch;
                        end
                        if (cur_field_reg == 2'd3)
                        begin
                            first3_next = ch;
                        end
                    end
                    field_len_next       = field_len_reg + 1'b1;
                    run_sum_next         = run_sum_reg + ch[5:0];
                    res_next.ev          = EV_DATA;
                    res_next.field_index = cur_field_reg;
                    res_next.data_char   = ch;
                end
            end

            if (clear_all)
            begin
                in_frame_next   = (head.cls == CLS_STX) && !in_frame_reg;
                in_dataset_next = 1'b0;
                cur_field_next  = 2'd0;
                field_len_next  = '0;
                run_sum_next    = '0;
                sum3_next       = '0;
                sum4_next       = '0;
                first2_next     = '0;
                first3_next     = '0;
                ds_count_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            in_dataset_reg <= 1'b0;
            cur_field_reg  <= '0;
            field_len_reg  <= '0;
            run_sum_reg    <= '0;
            sum3_reg       <= '0;
            sum4_reg       <= '0;
            first2_reg     <= '0;
            first3_reg     <= '0;
            ds_count_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            in_dataset_reg <= in_dataset_next;
            cur_field_reg  <= cur_field_next;
            field_len_reg  <= field_len_next;
            run_sum_reg    <= run_sum_next;
            sum3_reg       <= sum3_next;
            sum4_reg       <= sum4_next;
            first2_reg     <= first2_next;
            first3_reg     <= first3_next;
            ds_count_reg   <= ds_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    a_err_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.ev == EV_ERR) |-> (res_reg.err != ERR_NONE))
        else $error("error item without error code");

    a_code_only_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.ev != EV_ERR) |-> (res_reg.err == ERR_NONE))
        else $error("error code on a non-error item");

    a_no_pop_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !pop)
        else $error("result register overwritten while stalled");

    a_dataset_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        in_dataset_reg |-> in_frame_reg)
        else $error("dataset open outside a frame");

endmodule

### hw/rtl/tic_frame_stream_parser.sv
// ----------------------------------------------------------------------------
// tic_frame_stream_parser
// byte-serial parser for metering tele-information frames
// ----------------------------------------------------------------------------
// in_ch carries one received byte per item; out_ch returns one result item
// per byte: event, field index, data byte, timestamp flag, error code and the
// checksum character computed at cr.
// a byte accepted on in_ch is classified and written into the queue, taken from
// the queue by the back end, and its result is held in the output register.
// throughput is one byte per cycle while out_ch takes results without stalling;
// the per-byte state update in the back end is the single step each item needs.
// the two-entry queue lets the input keep accepting while a result waits in
// the output register; when out_ch stalls the queue fills and in_ch.ready
// drops until the result is taken.
// legacy_mode (offset 0) and max_datasets (offset 4) are written over the apb port;
// the user writes them only while the parser is idle, the block does not enforce it.
// reset clears the frame state, empties the queue, sets legacy_mode to 0 and
// max_datasets to 64; the parser then waits for stx.
// ----------------------------------------------------------------------------
module tic_frame_stream_parser
    import tfsp_pkg::*;
#(
    parameter int LABEL_MAX   = LABEL_MAX_DEF,
    parameter int VALUE_MAX   = VALUE_MAX_DEF,
    parameter int CHECK_MAX   = CHECK_MAX_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    tfsp_in_if.sink           in_ch,
    tfsp_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    cfg_wr;
    logic    q_full;
    logic    push;
    entry_t  push_entry;
    logic    pop;
    logic    q_valid;
    entry_t  head;
    result_t out_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_LEGACY_MODE:  cfg_next.legacy_mode  = pwdata[0];
                REG_MAX_DATASETS: cfg_next.max_datasets = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_LEGACY_MODE:  prdata = {31'd0, cfg_reg.legacy_mode};
            REG_MAX_DATASETS: prdata = {24'd0, cfg_reg.max_datasets};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.legacy_mode  <= 1'b0;
            cfg_reg.max_datasets <= MAX_DATASETS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tfsp_front u_front (
        .in_ch       (in_ch),
        .legacy_mode (cfg_reg.legacy_mode),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    tfsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .head       (head)
    );

    tfsp_back #(
        .LABEL_MAX (LABEL_MAX),
        .VALUE_MAX (VALUE_MAX),
        .CHECK_MAX (CHECK_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_res   (out_res)
    );

    assign out_ch.event_res         = out_res.ev;
    assign out_ch.field_index       = out_res.field_index;
    assign out_ch.data_char         = out_res.data_char;
    assign out_ch.has_timestamp     = out_res.has_timestamp;
    assign out_ch.error_code        = out_res.err;
    assign out_ch.computed_checksum = out_res.ck;

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the frame stream parser
// ----------------------------------------------------------------------------
// a byte-level model of the parser predicts one result item per received byte.
// a short directed run covers the framing corners. Random frames then follow
// under several register settings and handshake idling mixes. Most datasets
// are well formed with random content. The rest carry bad checksums, long
// fields, stray separators, restarts, noise and early frame ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import tfsp_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 265;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [ADDR_W-1:0] ADDR_LEGACY   = ADDR_W'(4 * int'(REG_LEGACY_MODE));
    localparam logic [ADDR_W-1:0] ADDR_MAX_SETS = ADDR_W'(4 * int'(REG_MAX_DATASETS));

    typedef enum int {
        CK_GOOD,
        CK_OFF,
        CK_ZERO
    } ck_mode_t;

    typedef enum int {
        FLAW_CKSUM,
        FLAW_LABEL_LONG,
        FLAW_CHECK_LONG,
        FLAW_VALUE_LONG,
        FLAW_RESTART,
        FLAW_ETX_OPEN,
        FLAW_EXTRA_SEP,
        FLAW_NOISE,
        FLAW_AFTER_CR,
        FLAW_STX,
        FLAW_SHORT,
        FLAW_ZERO_CHECK
    } flaw_t;

    class frame_scoreboard;
        logic       legacy_mode;
        logic [7:0] max_datasets;
        logic       in_frame;
        logic       in_dataset;
        logic [1:0] field_no;
        logic [5:0] field_len;
        logic [5:0] sum_all;
        logic [5:0] sum_three;
        logic [5:0] sum_four;
        logic [7:0] lead_two;
        logic [7:0] lead_three;
        logic [7:0] dataset_count;
        result_t    pending_events[$];
        int         mismatches;

        function new();
            legacy_mode  = 1'b0;
            max_datasets = MAX_DATASETS_RST;
            mismatches   = 0;
            drop_frame();
        endfunction

        function void open_dataset();
            in_dataset = 1'b1;
            field_no   = 2'd0;
            field_len  = '0;
            sum_all    = '0;
            sum_three  = '0;
            sum_four   = '0;
            lead_two   = '0;
            lead_three = '0;
        endfunction

        function void drop_frame();
            open_dataset();
            in_dataset    = 1'b0;
            in_frame      = 1'b0;
            dataset_count = '0;
        endfunction

        function result_t parse_byte(logic [7:0] ch);
            result_t    r;
            logic [7:0] sep;
            logic [7:0] last_sep;
            logic [7:0] lead;
            logic [6:0] ck;
            logic       four;
            int         total;
            int         limit;
            r        = '0;
            r.ev     = EV_IGNORE;
            r.err    = ERR_NONE;
            sep      = legacy_mode ? SEP_OLD : SEP_STD;
            last_sep = legacy_mode ? 8'h00 : sep;
            if (ch == B_STX) begin
                if (in_frame) begin
                    drop_frame();
                    r.ev  = EV_ERR;
                    r.err = ERR_STX;
                end
                else begin
                    drop_frame();
                    in_frame = 1'b1;
                    r.ev     = EV_FSTART;
                end
            end
            else if (!in_frame) begin
                r.ev = EV_IGNORE;
            end
            else if (ch == B_ETX) begin
                drop_frame();
                r.ev = EV_FEND;
            end
            else if (ch == B_LF) begin
                if (dataset_count >= max_datasets) begin
                    drop_frame();
                    r.ev  = EV_ERR;
                    r.err = ERR_DATASETS;
                end
                else begin
                    open_dataset();
                    r.ev = EV_DSTART;
                end
            end
            else if (!in_dataset) begin
                drop_frame();
                r.ev  = EV_ERR;
                r.err = ERR_OUTSIDE;
            end
            else if (ch == B_CR) begin
                four = (field_no == 2'd3) && (lead_three != 8'h00);
                if (four) begin
                    total = int'(sum_four);
                    lead  = lead_three;
                end
                else begin
                    if (field_no >= 2'd2)
                        total = int'(sum_three);
                    else
                        total = int'(sum_all) + ((field_no == 2'd0) ? int'(sep) : 0)
                              + int'(last_sep);
                    lead = lead_two;
                end
                ck = 7'(total % 64) + CK_OFFSET;
                if ({1'b0, ck} != lead) begin
                    drop_frame();
                    r.ev  = EV_ERR;
                    r.err = ERR_CHECKSUM;
                    r.ck  = ck;
                end
                else begin
                    in_dataset    = 1'b0;
                    dataset_count = dataset_count + 8'd1;
                    r.ev            = EV_DSOK;
                    r.has_timestamp = four;
                    r.ck            = ck;
                end
            end
            else if (ch == sep) begin
                if (field_no == 2'd3) begin
                    drop_frame();
                    r.ev  = EV_ERR;
                    r.err = ERR_FIELDS;
                end
                else begin
                    if (field_no == 2'd1)
                        sum_three = sum_all + last_sep[5:0];
                    if (field_no == 2'd2)
                        sum_four = sum_all + last_sep[5:0];
                    sum_all       = sum_all + sep[5:0];
                    r.ev          = EV_SEP;
                    r.field_index = field_no;
                    field_no      = field_no + 2'd1;
                    field_len     = '0;
                end
            end
            else begin
                limit = (field_no == 2'd0) ? LABEL_MAX_DEF
                      : (field_no == 2'd3) ? CHECK_MAX_DEF : VALUE_MAX_DEF;
                if (int'(field_len) >= limit) begin
                    drop_frame();
                    r.ev  = EV_ERR;
                    r.err = ERR_LENGTH;
                end
                else begin
                    if (field_len == '0 && field_no == 2'd2)
                        lead_two = ch;
                    if (field_len == '0 && field_no == 2'd3)
                        lead_three = ch;
                    field_len     = field_len + 6'd1;
                    sum_all       = sum_all + ch[5:0];
                    r.ev          = EV_DATA;
                    r.field_index = field_no;
                    r.data_char   = ch;
                end
            end
            return r;
        endfunction

        function void note_byte(logic [7:0] ch);
            pending_events.push_back(parse_byte(ch));
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_events.size() == 0) begin
                note_mismatch($sformatf("item with nothing expected: ev %0d err %0d",
                                        got.ev, got.err));
                return;
            end
            want = pending_events.pop_front();
            if (got.ev !== want.ev || got.field_index !== want.field_index ||
                got.data_char !== want.data_char ||
                got.has_timestamp !== want.has_timestamp ||
                got.err !== want.err || got.ck !== want.ck)
                note_mismatch($sformatf(
                    {"exp ev %0d fi %0d dc %02h ts %0d err %0d ck %02h / ",
                     "got ev %0d fi %0d dc %02h ts %0d err %0d ck %02h"},
                    want.ev, want.field_index, want.data_char, want.has_timestamp,
                    want.err, want.ck, got.ev, got.field_index, got.data_char,
                    got.has_timestamp, got.err, got.ck));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tfsp_in_if  in_if();
    tfsp_out_if out_if();

    frame_scoreboard sb;
    logic [7:0]      tx_bytes[$];
    int              bytes_sent     = 0;
    int              src_idle_pct   = 0;
    int              sink_stall_pct = 0;
    int              hold_left      = 0;
    int              stuck_cycles   = 0;

    int phase_legacy[6] = '{0, 1, 0, 1, 0, 1};
    int phase_max[6]    = '{64, 255, 1, 2, 255, 3};
    int phase_src[6]    = '{0, 60, 0, 16, 0, 60};
    int phase_sink[6]   = '{0, 0, 60, 16, 60, 0};

    tic_frame_stream_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] field_sep();
        return sb.legacy_mode ? SEP_OLD : SEP_STD;
    endfunction

    function automatic logic [7:0] rand_data();
        logic [7:0] b;
        if ($urandom_range(0, 29) == 0)
            return 8'h00;
        do
            b = 8'($urandom_range(0, 255));
        while (b == B_STX || b == B_ETX || b == B_LF || b == B_CR || b == field_sep());
        return b;
    endfunction

    function automatic int value_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, VALUE_MAX_DEF);
        return $urandom_range(0, 10);
    endfunction

    // n_fields fields ahead of the checksum field
    task automatic add_dataset(input int n_fields, input int len0, input int len1,
                               input int len2, input int ck_len, input ck_mode_t ck_mode);
        int         lens[3];
        int         total;
        logic [7:0] b;
        logic [6:0] ck;
        lens  = '{len0, len1, len2};
        total = 0;
        tx_bytes.push_back(B_LF);
        for (int f = 0; f < n_fields; f++)
        begin
            for (int i = 0; i < lens[f]; i++)
            begin
                b = rand_data();
                tx_bytes.push_back(b);
                total += int'(b);
            end
            tx_bytes.push_back(field_sep());
            if (f < n_fields - 1 || !sb.legacy_mode)
                total += int'(field_sep());
        end
        ck = 7'(total % 64) + CK_OFFSET;
        case (ck_mode)
            CK_OFF:  tx_bytes.push_back({1'b0, ck ^ 7'h01});
            CK_ZERO: tx_bytes.push_back(8'h00);
            default: tx_bytes.push_back({1'b0, ck});
        endcase
        repeat (ck_len - 1) tx_bytes.push_back(rand_data());
        tx_bytes.push_back(B_CR);
    endtask

    task automatic add_clean_dataset(input ck_mode_t ck_mode);
        add_dataset($urandom_range(2, 3), $urandom_range(1, LABEL_MAX_DEF), value_len(),
                    value_len(), $urandom_range(1, CHECK_MAX_DEF), ck_mode);
    endtask

    task automatic gen_frame();
        logic [7:0] b;
        flaw_t      flaw;
        repeat ($urandom_range(0, 2))
        begin
            b = 8'($urandom_range(0, 255));
            tx_bytes.push_back(b == B_STX ? B_ETX : b);
        end
        tx_bytes.push_back(B_STX);
        repeat ($urandom_range(0, 4))
        begin
            if ($urandom_range(0, 99) < 78) begin
                add_clean_dataset(CK_GOOD);
            end
            else begin
                flaw = flaw_t'($urandom_range(0, int'(FLAW_ZERO_CHECK)));
                case (flaw)
                    FLAW_CKSUM:      add_clean_dataset(CK_OFF);
                    FLAW_ZERO_CHECK: add_clean_dataset(CK_ZERO);
                    FLAW_LABEL_LONG: add_dataset(2, LABEL_MAX_DEF + 1, 2, 0, 1, CK_GOOD);
                    FLAW_VALUE_LONG: add_dataset(2, 3, VALUE_MAX_DEF + 1, 0, 1, CK_GOOD);
                    FLAW_CHECK_LONG: add_dataset(3, 3, 2, 2, CHECK_MAX_DEF + 1, CK_GOOD);
                    FLAW_RESTART:
                    begin
                        tx_bytes.push_back(B_LF);
                        repeat ($urandom_range(0, 3)) tx_bytes.push_back(rand_data());
                        add_clean_dataset(CK_GOOD);
                    end
                    FLAW_ETX_OPEN:
                    begin
                        tx_bytes.push_back(B_LF);
                        tx_bytes.push_back(rand_data());
                        tx_bytes.push_back(B_ETX);
                    end
                    FLAW_EXTRA_SEP:
                    begin
                        tx_bytes.push_back(B_LF);
                        tx_bytes.push_back(rand_data());
                        repeat (4) tx_bytes.push_back(field_sep());
                    end
                    FLAW_NOISE:
                    begin
                        repeat ($urandom_range(1, 6))
                            tx_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                    FLAW_AFTER_CR:
                    begin
                        add_clean_dataset(CK_GOOD);
                        tx_bytes.push_back(rand_data());
                    end
                    FLAW_STX:
                    begin
                        tx_bytes.push_back(B_LF);
                        tx_bytes.push_back(rand_data());
                        tx_bytes.push_back(B_STX);
                    end
                    FLAW_SHORT:
                    begin
                        tx_bytes.push_back(B_LF);
                        repeat ($urandom_range(0, 3)) tx_bytes.push_back(rand_data());
                        if ($urandom_range(0, 1) == 1)
                            tx_bytes.push_back(field_sep());
                        tx_bytes.push_back(B_CR);
                    end
                    default: add_clean_dataset(CK_GOOD);
                endcase
            end
        end
        if ($urandom_range(0, 9) != 0)
            tx_bytes.push_back(B_ETX);
    endtask

    // tasks start and end just after a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.rx_byte <= b;
        do
            @(posedge clk);
        while (in_if.ready !== 1'b1);
        sb.note_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_all();
        while (tx_bytes.size() > 0)
            send_byte(tx_bytes.pop_front());
    endtask

    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic legacy, input logic [7:0] max_sets);
        apb_write(ADDR_LEGACY, 32'(legacy));
        apb_write(ADDR_MAX_SETS, 32'(max_sets));
        sb.legacy_mode  = legacy;
        sb.max_datasets = max_sets;
    endtask

    // receiver side
    initial
    begin
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end
            else begin
                out_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got.ev            = event_t'(out_if.event_res);
            got.field_index   = out_if.field_index;
            got.data_char     = out_if.data_char;
            got.has_timestamp = out_if.has_timestamp;
            got.err           = err_t'(out_if.error_code);
            got.ck            = out_if.computed_checksum;
            sb.check_result(got);
        end
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        while (stuck_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int target;
        sb            = new();
        rst_n         = 1'b0;
        in_if.valid   = 1'b0;
        in_if.rx_byte = 8'h00;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        set_config(1'b0, MAX_DATASETS_RST);

        // ignored extremes, data before lf, restart, stray separator,
        // short dataset, etx in a dataset, stx in a frame
        tx_bytes = '{8'h00, 8'hFF, B_STX, 8'h41, B_STX, B_LF};
        add_dataset(2, 1, 0, 0, 1, CK_GOOD);
        tx_bytes.push_back(B_LF);
        repeat (4) tx_bytes.push_back(SEP_STD);
        tx_bytes.push_back(B_STX);
        tx_bytes.push_back(B_LF);
        tx_bytes.push_back(B_CR);
        tx_bytes.push_back(B_STX);
        tx_bytes.push_back(B_LF);
        tx_bytes.push_back(B_ETX);
        tx_bytes.push_back(B_STX);
        tx_bytes.push_back(B_STX);
        send_all();
        wait_drain();

        for (int p = 0; p < 6; p++)
        begin
            set_config(phase_legacy[p][0], 8'(phase_max[p]));
            src_idle_pct   = phase_src[p];
            sink_stall_pct = phase_sink[p];
            target         = bytes_sent + PHASE_ITEMS;
            if (p == 2)
                hold_left = HOLD_CYCLES;
            while (bytes_sent < target)
            begin
                gen_frame();
                send_all();
                if (p == 4 && $urandom_range(0, 3) == 0)
                    wait_drain();
            end
            wait_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_events.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
